/* rtl/xor_sprite_framebuffer_top_defines.svh */
// Assertion macros for the framebuffer RTL.
`ifndef XOR_SPRITE_FRAMEBUFFER_TOP_DEFINES_SVH
`define XOR_SPRITE_FRAMEBUFFER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define XSF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("framebuffer same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define XSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("framebuffer next-cycle check failed");

`endif

/* rtl/xsf_pkg.sv */
// Types, constants and codes shared by the framebuffer modules.
package xsf_pkg;

    // Screen geometry. Both sizes are powers of two, so wrapping is a plain truncation.
    localparam int SCREEN_COLUMNS = 64;
    localparam int SCREEN_ROWS    = 32;
    localparam int COL_W          = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W          = $clog2(SCREEN_ROWS);

    // One sprite row is eight pixels wide, one lane per pixel.
    localparam int SPRITE_W = 8;
    localparam int LANES    = SPRITE_W;
    localparam int LANE_W   = $clog2(LANES);

    localparam int COLOR_W = 24;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [COLOR_W-1:0] FG_RESET = {COLOR_W{1'b1}};
    localparam logic [COLOR_W-1:0] BG_RESET = '0;

    // Register indexes on the configuration port (paddr[2]).
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // What one lane reports: the frame bit it inverts and whether it hit a lit pixel.
    typedef struct packed {
        logic [SCREEN_COLUMNS-1:0] flip;
        logic                      hit;
    } t_lane_res;

endpackage

/* rtl/xsf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module xsf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/xsf_lane.sv */
// One pixel lane: places a sprite pixel on the frame row and tests it for a collision.
module xsf_lane import xsf_pkg::*; (
    input  logic [COL_W-1:0]          i_column,
    input  logic [LANE_W-1:0]         i_lane,
    input  logic                      i_pixel,
    input  logic [SCREEN_COLUMNS-1:0] i_old_row,
    output t_lane_res                 o_res
);

    logic [COL_W-1:0] pos;

    // The narrow add wraps at the screen edge on its own.
    assign pos        = i_column + COL_W'(i_lane);
    assign o_res.flip = i_pixel ? (SCREEN_COLUMNS'(1) << pos) : '0;
    assign o_res.hit  = i_pixel & i_old_row[pos];

endmodule

/* rtl/xsf_merge.sv */
// Combines the lane results into one flip mask and one collision bit.
module xsf_merge import xsf_pkg::*; (
    input  t_lane_res                 i_lanes [LANES],
    output logic [SCREEN_COLUMNS-1:0] o_mask,
    output logic                      o_hit
);

    always_comb begin
        o_mask = '0;
        o_hit  = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            o_mask = o_mask | i_lanes[i].flip;
            o_hit  = o_hit | i_lanes[i].hit;
        end
    end

endmodule

/* rtl/xor_sprite_framebuffer_top.sv */
// Top level of the XOR sprite framebuffer: item handshakes, frame RAM, lanes and result register.
// An item's result is loaded into the result register as the item leaves EXEC, which it does
// once that register is free. Items are taken one at a time, only in IDLE, for draw, clear
// and read alike; the frame row takes a read-modify-write on the RAM's single registered read port.
// Reset clears the control state, the row valid bits and the collision flag, and sets the colours
// to their defaults; the frame reads as blank at once, with no clearing pass.
`include "xor_sprite_framebuffer_top_defines.svh"

module xor_sprite_framebuffer_top import xsf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    // Input item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic [7:0]         i_column,
    input  logic [7:0]         i_row,
    input  logic [7:0]         i_sprite_bits,
    input  logic               i_first_row,
    input  logic               i_last_row,
    // Result item channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_collision,
    output logic               o_pixel_on,
    output logic [COLOR_W-1:0] o_pixel_color,
    output logic               o_sprite_done
);

    // ------------------------------------------------------------------
    // Configuration registers. The port is always ready; a write lands on
    // the access phase. Only address bit 2 selects the register, so the
    // low byte-offset bits are ignored.
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] r_fg_color;
    logic [COLOR_W-1:0] r_bg_color;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_color <= FG_RESET;
            r_bg_color <= BG_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_FG) begin
                r_fg_color <= pwdata[COLOR_W-1:0];
            end else begin
                r_bg_color <= pwdata[COLOR_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_BG) begin
            prdata = DATA_W'(r_bg_color);
        end else begin
            prdata = DATA_W'(r_fg_color);
        end
    end

    // ------------------------------------------------------------------
    // Control. An item is captured in IDLE and its frame row is read from
    // the RAM at the same edge. In EXEC the row data is back; the item
    // completes as soon as the result register is free (empty, or being
    // emptied in this cycle), writing the row back for a draw and loading the result.
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;
    logic   in_fire;
    logic   out_free;
    logic   exec_done;

    assign in_fire  = i_in_valid & o_in_ready;
    assign out_free = !o_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        exec_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_EXEC: begin
                exec_done = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
                exec_done  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Captured item. The coordinates wrap by keeping only the low bits.
    logic [1:0]          r_func;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [SPRITE_W-1:0] r_bits;
    logic                r_first;
    logic                r_last;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func  <= i_func;
            r_col   <= i_column[COL_W-1:0];
            r_row   <= i_row[ROW_W-1:0];
            r_bits  <= i_sprite_bits;
            r_first <= i_first_row;
            r_last  <= i_last_row;
        end
    end

    // ------------------------------------------------------------------
    // Frame store. One RAM word per screen row, bit x being column x. A
    // valid bit per row stands in for the contents after reset or a clear:
    // a row whose bit is low reads as blank, so a clear never writes the RAM.
    // ------------------------------------------------------------------
    logic [SCREEN_COLUMNS-1:0] rd_data;
    logic [SCREEN_COLUMNS-1:0] old_row;
    logic [SCREEN_COLUMNS-1:0] new_row;
    logic [SCREEN_ROWS-1:0]    r_row_valid;
    logic                      draw_wr;

    assign draw_wr = exec_done && (r_func == FUNC_DRAW);
    assign old_row = r_row_valid[r_row] ? rd_data : '0;

    xsf_ram #(
        .WIDTH (SCREEN_COLUMNS),
        .DEPTH (SCREEN_ROWS)
    ) u_frame (
        .i_clk     (i_clk),
        .i_wr_en   (draw_wr),
        .i_wr_addr (r_row),
        .i_wr_data (new_row),
        .i_rd_en   (in_fire),
        .i_rd_addr (i_row[ROW_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (exec_done && (r_func == FUNC_CLEAR)) begin
            r_row_valid <= '0;
        end else if (draw_wr) begin
            r_row_valid[r_row] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Pixel lanes. Each lane takes one sprite pixel, leftmost in lane 0,
    // and works out which frame bit it inverts and whether that bit was
    // lit. The merge stage ORs the lanes into a flip mask and a hit.
    // ------------------------------------------------------------------
    t_lane_res lane_res [LANES];
    logic [SCREEN_COLUMNS-1:0] flip_mask;
    logic                      any_hit;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        xsf_lane u_lane (
            .i_column  (r_col),
            .i_lane    (LANE_W'(g)),
            .i_pixel   (r_bits[SPRITE_W-1-g]),
            .i_old_row (old_row),
            .o_res     (lane_res[g])
        );
    end

    xsf_merge u_merge (
        .i_lanes (lane_res),
        .o_mask  (flip_mask),
        .o_hit   (any_hit)
    );

    assign new_row = old_row ^ flip_mask;

    // ------------------------------------------------------------------
    // Collision flag. A first row clears it before its own hits are
    // counted; other rows can only set it. Clear and read leave it alone.
    // ------------------------------------------------------------------
    logic r_coll;
    logic n_coll;

    always_comb begin
        n_coll = r_coll;
        if (r_func == FUNC_DRAW) begin
            n_coll = (r_coll & !r_first) | any_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll <= 1'b0;
        end else if (exec_done) begin
            r_coll <= n_coll;
        end
    end

    // ------------------------------------------------------------------
    // Result register. It parts the two sides: a new item may be taken
    // while a finished result still waits here.
    // ------------------------------------------------------------------
    logic               r_out_valid;
    logic               r_out_coll;
    logic               r_out_on;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_done;
    logic               n_out_on;
    logic [COLOR_W-1:0] n_out_color;
    logic               n_out_done;

    always_comb begin
        n_out_on    = 1'b0;
        n_out_color = '0;
        n_out_done  = 1'b0;
        case (r_func)
            FUNC_DRAW: begin
                n_out_done = r_last;
            end
            FUNC_CLEAR: begin
                n_out_done = 1'b1;
            end
            FUNC_READ: begin
                n_out_on    = old_row[r_col];
                n_out_color = old_row[r_col] ? r_fg_color : r_bg_color;
            end
            default: begin
                n_out_on = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_done) begin
            r_out_coll  <= n_coll;
            r_out_on    <= n_out_on;
            r_out_color <= n_out_color;
            r_out_done  <= n_out_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_collision   = r_out_coll;
    assign o_pixel_on    = r_out_on;
    assign o_pixel_color = r_out_color;
    assign o_sprite_done = r_out_done;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `XSF_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, in_fire, r_state == S_EXEC)
    `XSF_ASSERT_NEXT(a_done_gives_result, i_clk, i_rst_n, exec_done, o_out_valid)
    `XSF_ASSERT_NEXT(a_clear_blanks, i_clk, i_rst_n,
        exec_done && (r_func == FUNC_CLEAR), r_row_valid == '0)
    `XSF_ASSERT_SAME(a_no_write_on_accept, i_clk, i_rst_n, in_fire, !draw_wr)

endmodule

/* verif/tb.sv */
// Self-checking testbench for the XOR sprite framebuffer top level.
module tb import xsf_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // Function code 3 is not defined by the block; it must leave the state alone.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int          PHASES        = 6;
    localparam int          PHASE_ITEMS   = 315;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int          DIRECTED_ROWS = 20;

    typedef struct {
        logic [1:0] func;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] bits;
        logic       first;
        logic       last;
    } t_item;

    typedef struct packed {
        logic               collision;
        logic               on;
        logic [COLOR_W-1:0] color;
        logic               done;
    } t_result;

    // One row of the directed table. Where typed is set, want is the result read off by hand;
    // elsewhere the frame model supplies the expectation.
    typedef struct {
        logic [1:0] func;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] bits;
        logic       first;
        logic       last;
        bit         typed;
        t_result    want;
    } t_vector;

    // Clock, reset and all inputs of the block start at known values.
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [ADDR_W-1:0]  paddr         = '0;
    logic [DATA_W-1:0]  pwdata        = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_func        = FUNC_DRAW;
    logic [7:0]         i_column      = '0;
    logic [7:0]         i_row         = '0;
    logic [7:0]         i_sprite_bits = '0;
    logic               i_first_row   = 1'b0;
    logic               i_last_row    = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b1;
    logic               o_collision;
    logic               o_pixel_on;
    logic [COLOR_W-1:0] o_pixel_color;
    logic               o_sprite_done;

    // Model of the frame: one bit per pixel, bit x of a row word being column x.
    logic [SCREEN_COLUMNS-1:0] frame_image [SCREEN_ROWS];
    logic                      sprite_hit  = 1'b0;
    logic [COLOR_W-1:0]        lit_colour  = FG_RESET;
    logic [COLOR_W-1:0]        dark_colour = BG_RESET;

    t_result     pending_results [$];
    int          mismatches    = 0;
    int unsigned cycles        = 0;
    bit          idle_on       = 1'b1;
    bit          hold_request  = 1'b0;
    t_vector     directed_rows [DIRECTED_ROWS];

    xor_sprite_framebuffer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_column      (i_column),
        .i_row         (i_row),
        .i_sprite_bits (i_sprite_bits),
        .i_first_row   (i_first_row),
        .i_last_row    (i_last_row),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_collision   (o_collision),
        .o_pixel_on    (o_pixel_on),
        .o_pixel_color (o_pixel_color),
        .o_sprite_done (o_sprite_done)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one accepted item to the frame model and returns the result it must produce.
    // The sprite row XORs into the frame with wrap-around; any lit pixel hit by a set sprite
    // bit raises the collision flag, which only a first row of a new sprite lowers again.
    function automatic t_result frame_response(input t_item it);
        t_result r;
        int      x;
        int      y;
        int      px;
        logic    s;
        r = '0;
        x = int'(it.column) % SCREEN_COLUMNS;
        y = int'(it.row) % SCREEN_ROWS;
        case (it.func)
            FUNC_DRAW: begin
                if (it.first) begin
                    sprite_hit = 1'b0;
                end
                for (int j = 0; j < SPRITE_W; j++) begin
                    px = (x + j) % SCREEN_COLUMNS;
                    s  = it.bits[SPRITE_W-1-j];
                    if (s && frame_image[y][px]) begin
                        sprite_hit = 1'b1;
                    end
                    frame_image[y][px] = frame_image[y][px] ^ s;
                end
                r.done = it.last;
            end
            FUNC_CLEAR: begin
                for (int k = 0; k < SCREEN_ROWS; k++) begin
                    frame_image[k] = '0;
                end
                r.done = 1'b1;
            end
            FUNC_READ: begin
                r.on    = frame_image[y][x];
                r.color = r.on ? lit_colour : dark_colour;
            end
            default: begin
            end
        endcase
        r.collision = sprite_hit;
        return r;
    endfunction

    // Offers one item, holding valid and the payload steady until the block takes it, and
    // records the expected result at the accepting edge. A random gap may precede the item.
    task automatic offer_item(input t_item it, input bit typed, input t_result want);
        int      gap;
        t_result predicted;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= it.func;
        i_column      <= it.column;
        i_row         <= it.row;
        i_sprite_bits <= it.bits;
        i_first_row   <= it.first;
        i_last_row    <= it.last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = frame_response(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Waits until every expected result has come back, then lets the pipeline run dry.
    task automatic settle();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one colour register, with junk in the unused upper bits, and reads it back.
    task automatic write_colour(input logic idx, input logic [COLOR_W-1:0] value);
        logic [DATA_W-1:0] word;
        word                = $urandom;
        word[COLOR_W-1:0]   = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_FG) begin
            lit_colour = value;
        end else begin
            dark_colour = value;
        end
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[COLOR_W-1:0] !== value) begin
            $display("%0t: register %0d read back expected %06h got %06h",
                     $time, idx, value, prdata[COLOR_W-1:0]);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stimulus: reset, a directed table, then random phases under different colour settings.
    initial begin : stimulus
        t_item   it;
        t_result none;
        int      sprite_x;
        int      sprite_y;
        int      height;
        int      pick;
        int      sent;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;

        for (int k = 0; k < SCREEN_ROWS; k++) begin
            frame_image[k] = '0;
        end
        none     = '0;
        sprite_x = 0;
        sprite_y = 0;
        height   = 1;

        // The directed table starts from the reset state: blank frame, white on black.
        directed_rows = '{
            '{FUNC_READ,   8'd0,   8'd0,   8'h00, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 24'h0, 1'b0}},
            '{FUNC_READ,   8'd255, 8'd255, 8'hFF, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 24'h0, 1'b0}},
            '{FUNC_DRAW,   8'd0,   8'd0,   8'hFF, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 24'h0, 1'b1}},
            '{FUNC_READ,   8'd0,   8'd0,   8'h00, 1'b0, 1'b0, 1'b1,
              '{1'b0, 1'b1, 24'hFFFFFF, 1'b0}},
            '{FUNC_READ,   8'd7,   8'd0,   8'h00, 1'b0, 1'b0, 1'b1,
              '{1'b0, 1'b1, 24'hFFFFFF, 1'b0}},
            '{FUNC_READ,   8'd8,   8'd0,   8'h00, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 24'h0, 1'b0}},
            '{FUNC_DRAW,   8'd0,   8'd0,   8'h80, 1'b1, 1'b0, 1'b1, '{1'b1, 1'b0, 24'h0, 1'b0}},
            '{FUNC_READ,   8'd0,   8'd0,   8'h00, 1'b0, 1'b0, 1'b1, '{1'b1, 1'b0, 24'h0, 1'b0}},
            '{FUNC_DRAW,   8'd60,  8'd31,  8'hFF, 1'b0, 1'b1, 1'b0, none},
            '{FUNC_READ,   8'd3,   8'd31,  8'h00, 1'b0, 1'b0, 1'b0, none},
            '{FUNC_READ,   8'd59,  8'd31,  8'h00, 1'b0, 1'b0, 1'b0, none},
            '{FUNC_READ,   8'd188, 8'd95,  8'h00, 1'b0, 1'b0, 1'b0, none},
            '{FUNC_DRAW,   8'd255, 8'd255, 8'hAA, 1'b1, 1'b0, 1'b0, none},
            '{FUNC_DRAW,   8'd64,  8'd32,  8'h00, 1'b0, 1'b0, 1'b0, none},
            '{FUNC_UNUSED, 8'd255, 8'd255, 8'hFF, 1'b1, 1'b1, 1'b0, none},
            '{FUNC_CLEAR,  8'd0,   8'd0,   8'h00, 1'b0, 1'b0, 1'b0, none},
            '{FUNC_READ,   8'd63,  8'd31,  8'h00, 1'b0, 1'b0, 1'b0, none},
            '{FUNC_DRAW,   8'd0,   8'd0,   8'hFF, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 24'h0, 1'b1}},
            '{FUNC_DRAW,   8'd0,   8'd0,   8'hFF, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b0, 24'h0, 1'b1}},
            '{FUNC_READ,   8'd0,   8'd0,   8'h00, 1'b0, 1'b0, 1'b1, '{1'b1, 1'b0, 24'h0, 1'b0}}
        };

        // Reset is held low from the start and is never asserted again.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            it = '{directed_rows[n].func, directed_rows[n].column, directed_rows[n].row,
                   directed_rows[n].bits, directed_rows[n].first, directed_rows[n].last};
            offer_item(it, directed_rows[n].typed, directed_rows[n].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            // The colours only change once the block has gone quiet.
            i_in_valid <= 1'b0;
            settle();
            case (phase)
                0:       begin fg = '0;  bg = '1; end
                2:       begin fg = '1;  bg = '0; end
                4:       begin fg = '0;  bg = '0; end
                default: begin fg = COLOR_W'($urandom); bg = COLOR_W'($urandom); end
            endcase
            write_colour(REG_FG, fg);
            write_colour(REG_BG, bg);

            // In the second phase the receiver holds off for a long stretch, so that results
            // back up and the input side stalls. The last phase runs without any idling.
            hold_request = (phase == 1);
            idle_on      = (phase != PHASES - 1);

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    // A well-formed sprite: consecutive rows, first and last marked.
                    height   = $urandom_range(1, 15);
                    sprite_x = $urandom_range(0, 255);
                    sprite_y = $urandom_range(0, 255);
                    for (int k = 0; k < height; k++) begin
                        it.func   = FUNC_DRAW;
                        it.column = sprite_x[7:0];
                        it.row    = 8'(sprite_y + k);
                        it.bits   = 8'($urandom_range(0, 255));
                        it.first  = (k == 0);
                        it.last   = (k == height - 1);
                        offer_item(it, 1'b0, none);
                    end
                    sent += height;
                end else begin
                    it.bits  = 8'($urandom_range(0, 255));
                    it.first = 1'($urandom_range(0, 1));
                    it.last  = 1'($urandom_range(0, 1));
                    if (pick < 85) begin
                        // Reads land on the last sprite, aliased through the upper address
                        // bits, so that lit pixels turn up often.
                        it.func   = FUNC_READ;
                        it.column = 8'(sprite_x + $urandom_range(0, 7) + 64 * $urandom_range(0, 3));
                        it.row    = 8'(sprite_y + $urandom_range(0, height - 1)
                                       + 32 * $urandom_range(0, 7));
                    end else begin
                        if (pick < 87) begin
                            it.func = FUNC_CLEAR;
                        end else if (pick < 90) begin
                            it.func = FUNC_UNUSED;
                        end else begin
                            it.func = 2'($urandom_range(0, 3));
                        end
                        it.column = 8'($urandom_range(0, 255));
                        it.row    = 8'($urandom_range(0, 255));
                    end
                    offer_item(it, 1'b0, none);
                    sent++;
                end
            end
        end

        i_in_valid <= 1'b0;
        settle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Receiver pacing: random stall bursts, plus one long hold-off counted here.
    initial begin : result_pacing
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 15);
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Every accepted result is compared, field by field, with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result seen;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = '{o_collision, o_pixel_on, o_pixel_color, o_sprite_done};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item, expected none got %b/%b/%06h/%b",
                         $time, seen.collision, seen.on, seen.color, seen.done);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (seen.collision !== want.collision) begin
                    $display("%0t: collision expected %b got %b",
                             $time, want.collision, seen.collision);
                    mismatches++;
                end
                if (seen.on !== want.on) begin
                    $display("%0t: pixel_on expected %b got %b", $time, want.on, seen.on);
                    mismatches++;
                end
                if (seen.color !== want.color) begin
                    $display("%0t: pixel_color expected %06h got %06h",
                             $time, want.color, seen.color);
                    mismatches++;
                end
                if (seen.done !== want.done) begin
                    $display("%0t: sprite_done expected %b got %b", $time, want.done, seen.done);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
